// File: hdl/baro_temp_press_compensation_top_assert.svh
// Assertion macros for the barometric compensation block.
// Used by the top level only; expects signals named clock and reset in scope.
`ifndef BARO_TEMP_PRESS_COMPENSATION_TOP_ASSERT_SVH
`define BARO_TEMP_PRESS_COMPENSATION_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define BTPC_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset
`define BTPC_ASSERT_NXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/btpc_pkg.sv
// Shared types and constants for the barometric compensation block.
// No dependencies; imported by every module of the block.
package btpc_pkg;

   // Register indexes on the configuration port
   localparam logic [1:0] REG_TEMP_CALIB = 2'd0;
   localparam logic [1:0] REG_PRESS_LOW  = 2'd1;
   localparam logic [1:0] REG_PRESS_MID  = 2'd2;
   localparam logic [1:0] REG_PRESS_HIGH = 2'd3;

   localparam logic signed [60:0] TEMP_OUT_MAX = 61'sd8388607;
   localparam logic signed [60:0] TEMP_OUT_MIN = -61'sd8388608;
   localparam logic signed [60:0] T_INT_MAX    = 61'sd134217727;
   localparam logic signed [60:0] T_INT_MIN    = -61'sd134217728;
   localparam logic signed [16:0] P_OFFSET     = 17'sd16384;

   // Pressure limit before the divide by 100 (100 * 2^27)
   localparam logic signed [57:0] SAT_LIMIT     = 58'sd13421772800;
   localparam logic [26:0]        PRESS_OUT_MAX = 27'h7FFFFFF;
   // Reciprocal of 25 for a 32-bit dividend: ceil(2^37 / 25)
   localparam logic [32:0]        RECIP_25      = 33'd5497558139;
   localparam int                 RECIP_SHIFT   = 37;

   typedef struct packed {
      logic [15:0]        t1;
      logic [15:0]        t2;
      logic signed [7:0]  t3;
      logic signed [15:0] p1;
      logic signed [15:0] p2;
      logic signed [7:0]  p3;
      logic signed [7:0]  p4;
      logic [15:0]        p5;
      logic [15:0]        p6;
      logic signed [7:0]  p7;
      logic signed [7:0]  p8;
      logic signed [15:0] p9;
      logic signed [7:0]  p10;
      logic signed [7:0]  p11;
   } calib_type;

endpackage

// File: hdl/btpc_csr.sv
// Calibration register file on an APB-style port.
// Depends on btpc_pkg for register indexes and the calibration struct.
module btpc_csr import btpc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output calib_type   calib
);

   logic [39:0] temp_calib_ff;
   logic [47:0] press_low_ff;
   logic [31:0] press_mid_ff;
   logic [47:0] press_high_ff;
   logic [1:0]  index;
   logic        wr_en;

   assign index = csr_paddr[4:3];
   assign wr_en = csr_psel & csr_penable & csr_pwrite;

   // Write on the access cycle of a transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         temp_calib_ff <= '0;
         press_low_ff  <= '0;
         press_mid_ff  <= '0;
         press_high_ff <= '0;
      end else if (wr_en) begin
         unique case (index)
            REG_TEMP_CALIB: temp_calib_ff <= csr_pwdata[39:0];
            REG_PRESS_LOW:  press_low_ff  <= csr_pwdata[47:0];
            REG_PRESS_MID:  press_mid_ff  <= csr_pwdata[31:0];
            REG_PRESS_HIGH: press_high_ff <= csr_pwdata[47:0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      unique case (index)
         REG_TEMP_CALIB: csr_prdata = {24'd0, temp_calib_ff};
         REG_PRESS_LOW:  csr_prdata = {16'd0, press_low_ff};
         REG_PRESS_MID:  csr_prdata = {32'd0, press_mid_ff};
         REG_PRESS_HIGH: csr_prdata = {16'd0, press_high_ff};
         default:        csr_prdata = '0;
      endcase
   end

   // Unpack the calibration fields
   always_comb begin
      calib.t1  = temp_calib_ff[15:0];
      calib.t2  = temp_calib_ff[31:16];
      calib.t3  = temp_calib_ff[39:32];
      calib.p1  = press_low_ff[15:0];
      calib.p2  = press_low_ff[31:16];
      calib.p3  = press_low_ff[39:32];
      calib.p4  = press_low_ff[47:40];
      calib.p5  = press_mid_ff[15:0];
      calib.p6  = press_mid_ff[31:16];
      calib.p7  = press_high_ff[7:0];
      calib.p8  = press_high_ff[15:8];
      calib.p9  = press_high_ff[31:16];
      calib.p10 = press_high_ff[39:32];
      calib.p11 = press_high_ff[47:40];
   end

endmodule

// File: hdl/btpc_temp.sv
// Temperature stages: quadratic in the raw reading, output and clamped internal value.
// Depends on btpc_pkg for the calibration struct and limits.
module btpc_temp import btpc_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  logic [23:0]        press_raw,
   input  logic [23:0]        temp_raw,
   input  calib_type          calib,
   output logic               out_valid,
   output logic signed [27:0] t_out,
   output logic signed [23:0] tq_out,
   output logic [23:0]        pr_out
);

   localparam int TQ_SHIFT = 48 - FRAC_BITS;

   logic [3:0] valid_ff;
   logic [23:0] pr_ff [4];

   logic signed [24:0] d_ff, d_in;
   logic signed [41:0] dt2_ff, dt2_in;
   logic signed [49:0] dd_ff, dd_in;
   logic signed [60:0] t48_ff, t48_in;
   logic signed [57:0] ddt3;
   logic signed [60:0] tq_full, t_full;
   logic signed [27:0] t_ff, t_in;
   logic signed [23:0] tq_ff, tq_in;

   always_comb begin
      d_in   = $signed({1'b0, temp_raw}) - $signed({1'b0, calib.t1, 8'd0});
      dt2_in = d_ff * $signed({1'b0, calib.t2});
      dd_in  = d_ff * d_ff;
      ddt3   = dd_ff * calib.t3;
      t48_in = (61'(dt2_ff) <<< 18) + 61'(ddt3);

      // Saturate the output temperature
      tq_full = t48_ff >>> TQ_SHIFT;
      if (tq_full > TEMP_OUT_MAX) begin
         tq_in = TEMP_OUT_MAX[23:0];
      end else if (tq_full < TEMP_OUT_MIN) begin
         tq_in = TEMP_OUT_MIN[23:0];
      end else begin
         tq_in = tq_full[23:0];
      end

      // Clamp the 20-fraction-bit temperature used for pressure
      t_full = t48_ff >>> 28;
      if (t_full > T_INT_MAX) begin
         t_in = T_INT_MAX[27:0];
      end else if (t_full < T_INT_MIN) begin
         t_in = T_INT_MIN[27:0];
      end else begin
         t_in = t_full[27:0];
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (adv) begin
         d_ff     <= d_in;
         dt2_ff   <= dt2_in;
         dd_ff    <= dd_in;
         t48_ff   <= t48_in;
         t_ff     <= t_in;
         tq_ff    <= tq_in;
         pr_ff[0] <= press_raw;
         for (int i = 1; i < 4; i++) begin
            pr_ff[i] <= pr_ff[i-1];
         end
      end
   end

   assign out_valid = valid_ff[3];
   assign t_out     = t_ff;
   assign tq_out    = tq_ff;
   assign pr_out    = pr_ff[3];

endmodule

// File: hdl/btpc_press.sv
// Pressure polynomial stages: powers of temperature, calibration products and the sum.
// Depends on btpc_pkg for the calibration struct and offsets.
module btpc_press import btpc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  logic signed [27:0] t_in,
   input  logic signed [23:0] tq_in,
   input  logic [23:0]        pr_in,
   input  calib_type          calib,
   output logic               out_valid,
   output logic signed [57:0] sum_out,
   output logic signed [23:0] tq_out
);

   localparam int DEPTH = 7;

   logic [DEPTH-1:0]   valid_ff;
   logic signed [23:0] tq_ff [DEPTH];
   logic [23:0]        pr_ff [5];

   logic signed [16:0] p1m, p2m;
   logic signed [55:0] tt;

   // First multiply stage
   logic signed [35:0] ts5_ff, ts5_in;
   logic signed [27:0] t5_ff;
   logic signed [44:0] p6t5_ff, p6t5_in, p2t5_ff, p2t5_in;
   logic signed [37:0] e5_ff, e5_in;
   logic signed [32:0] f5_ff, f5_in;
   logic [47:0]        r2_5_ff, r2_5_in;

   // Second multiply stage
   logic signed [62:0] tsc6_ff, tsc6_in, he6_ff, he6_in, le6_ff, le6_in;
   logic signed [43:0] p7ts6_ff, p7ts6_in, p3ts6_ff, p3ts6_in;
   logic signed [57:0] hf6_ff, hf6_in, lf6_ff, lf6_in;
   logic signed [44:0] p6t6_ff, p2t6_ff;

   // Partial sums
   logic signed [42:0] tc7_ff, tc7_in;
   logic signed [63:0] me, mf;
   logic signed [50:0] mse7_ff, mse7_in, msf7_ff, msf7_in;
   logic signed [57:0] acca7_ff, acca7_in;
   logic signed [39:0] cpart7_ff, cpart7_in;

   logic signed [50:0] p8tc8_ff, p8tc8_in, p4tc8_ff, p4tc8_in;
   logic signed [57:0] suma8_ff, suma8_in;
   logic signed [39:0] cpart8_ff;

   logic signed [39:0] c9_ff, c9_in;
   logic signed [57:0] sumb9_ff, sumb9_in;

   logic signed [44:0] pch10_ff, pch10_in, pcl10_ff, pcl10_in;
   logic signed [57:0] sumb10_ff;

   logic signed [63:0] prc;
   logic signed [57:0] sum11_ff, sum11_in;

   always_comb begin
      p1m = 17'(calib.p1) - P_OFFSET;
      p2m = 17'(calib.p2) - P_OFFSET;

      // Powers of temperature, the terms linear in it and the raw pressure products
      tt       = t_in * t_in;
      ts5_in   = 36'(tt >>> 20);
      p6t5_in  = $signed({1'b0, calib.p6}) * t_in;
      p2t5_in  = p2m * t_in;
      e5_in    = (38'(calib.p9) <<< 20) + 38'(calib.p10) * 38'(t_in);
      f5_in    = $signed({1'b0, pr_in}) * calib.p11;
      r2_5_in  = pr_in * pr_in;

      tsc6_in  = ts5_ff * t5_ff;
      p7ts6_in = calib.p7 * ts5_ff;
      p3ts6_in = calib.p3 * ts5_ff;
      he6_in   = $signed({1'b0, r2_5_ff[47:24]}) * e5_ff;
      le6_in   = $signed({1'b0, r2_5_ff[23:0]}) * e5_ff;
      hf6_in   = $signed({1'b0, r2_5_ff[47:24]}) * f5_ff;
      lf6_in   = $signed({1'b0, r2_5_ff[23:0]}) * f5_ff;

      // Recombine the split square-term products with exact floors
      tc7_in    = 43'(tsc6_ff >>> 20);
      me        = (64'(he6_ff) + (64'(le6_ff) >>> 24)) >>> 12;
      mf        = (64'(hf6_ff) + (64'(lf6_ff) >>> 24)) >>> 9;
      mse7_in   = 51'(me);
      msf7_in   = 51'(mf);
      acca7_in  = ($signed({1'b0, calib.p5, 35'd0}) >>> 0) + (58'(p6t6_ff) <<< 6)
                  + (58'(p7ts6_ff) <<< 4);
      cpart7_in = (40'(p1m) <<< 20) + 40'(p2t6_ff >>> 9) + 40'(p3ts6_ff >>> 12);

      p8tc8_in  = calib.p8 * tc7_ff;
      p4tc8_in  = calib.p4 * tc7_ff;
      suma8_in  = acca7_ff + 58'(mse7_ff) + 58'(msf7_ff);

      c9_in     = cpart8_ff + 40'(p4tc8_ff >>> 17);
      sumb9_in  = suma8_ff + 58'(p8tc8_ff >>> 3);

      // Raw pressure times the linear coefficient, split in two halves
      pch10_in  = $signed({1'b0, pr_ff[4]}) * $signed(c9_ff[39:20]);
      pcl10_in  = $signed({1'b0, pr_ff[4]}) * $signed({1'b0, c9_ff[19:0]});

      prc       = (64'(pch10_ff) <<< 20) + 64'(pcl10_ff);
      sum11_in  = sumb10_ff + 58'(prc >>> 8);
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[DEPTH-2:0], in_valid};
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (adv) begin
         ts5_ff    <= ts5_in;
         t5_ff     <= t_in;
         p6t5_ff   <= p6t5_in;
         p2t5_ff   <= p2t5_in;
         e5_ff     <= e5_in;
         f5_ff     <= f5_in;
         r2_5_ff   <= r2_5_in;
         tsc6_ff   <= tsc6_in;
         p7ts6_ff  <= p7ts6_in;
         p3ts6_ff  <= p3ts6_in;
         he6_ff    <= he6_in;
         le6_ff    <= le6_in;
         hf6_ff    <= hf6_in;
         lf6_ff    <= lf6_in;
         p6t6_ff   <= p6t5_ff;
         p2t6_ff   <= p2t5_ff;
         tc7_ff    <= tc7_in;
         mse7_ff   <= mse7_in;
         msf7_ff   <= msf7_in;
         acca7_ff  <= acca7_in;
         cpart7_ff <= cpart7_in;
         p8tc8_ff  <= p8tc8_in;
         p4tc8_ff  <= p4tc8_in;
         suma8_ff  <= suma8_in;
         cpart8_ff <= cpart7_ff;
         c9_ff     <= c9_in;
         sumb9_ff  <= sumb9_in;
         pch10_ff  <= pch10_in;
         pcl10_ff  <= pcl10_in;
         sumb10_ff <= sumb9_ff;
         sum11_ff  <= sum11_in;
         tq_ff[0]  <= tq_in;
         for (int i = 1; i < DEPTH; i++) begin
            tq_ff[i] <= tq_ff[i-1];
         end
         pr_ff[0]  <= pr_in;
         for (int i = 1; i < 5; i++) begin
            pr_ff[i] <= pr_ff[i-1];
         end
      end
   end

   assign out_valid = valid_ff[DEPTH-1];
   assign sum_out   = sum11_ff;
   assign tq_out    = tq_ff[DEPTH-1];

endmodule

// File: hdl/btpc_pdiv.sv
// Output stages: scale the pressure sum, clamp it and divide by 100.
// Depends on btpc_pkg for the limit and reciprocal constants.
module btpc_pdiv import btpc_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  logic signed [57:0] sum_in,
   input  logic signed [23:0] tq_in,
   output logic               out_valid,
   output logic signed [23:0] temp_out,
   output logic [26:0]        press_out
);

   localparam int SUM_SHIFT = 32 - FRAC_BITS;

   logic [2:0]         valid_ff;
   logic signed [23:0] tq_ff [3];

   logic signed [57:0] sq;
   logic               neg12_ff, neg12_in, sat12_ff, sat12_in;
   logic [31:0]        x12_ff, x12_in;
   logic               neg13_ff, sat13_ff;
   logic [64:0]        q13_ff, q13_in;
   logic [26:0]        pq_ff, pq_in;

   always_comb begin
      // Scale to the output fraction and flag the clamped cases
      sq       = sum_in >>> SUM_SHIFT;
      neg12_in = sum_in[57];
      sat12_in = !sum_in[57] && (sq >= SAT_LIMIT);
      x12_in   = sq[33:2];

      // Divide by 4 above, by 25 here through the reciprocal
      q13_in   = 65'(x12_ff) * 65'(RECIP_25);

      if (neg13_ff) begin
         pq_in = '0;
      end else if (sat13_ff) begin
         pq_in = PRESS_OUT_MAX;
      end else begin
         pq_in = q13_ff[RECIP_SHIFT+26:RECIP_SHIFT];
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (adv) begin
         neg12_ff <= neg12_in;
         sat12_ff <= sat12_in;
         x12_ff   <= x12_in;
         neg13_ff <= neg12_ff;
         sat13_ff <= sat12_ff;
         q13_ff   <= q13_in;
         pq_ff    <= pq_in;
         tq_ff[0] <= tq_in;
         tq_ff[1] <= tq_ff[0];
         tq_ff[2] <= tq_ff[1];
      end
   end

   assign out_valid = valid_ff[2];
   assign temp_out  = tq_ff[2];
   assign press_out = pq_ff;

endmodule

// File: hdl/baro_temp_press_compensation_top.sv
// Barometric temperature and pressure compensation, fully pipelined.
// Each sample pair passes the temperature, pressure and output stages in order, held only while the result stalls.
// Throughput: one sample pair per cycle; the pipeline halts as a whole when the result waits.
// Reset: synchronous, active high; clears valid bits and calibration registers to zero.
// Depends on btpc_pkg, btpc_csr, btpc_temp, btpc_press, btpc_pdiv and the assertion header.
`include "baro_temp_press_compensation_top_assert.svh"
module baro_temp_press_compensation_top import btpc_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [23:0]        req_press_raw,
   input  logic [23:0]        req_temp_raw,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [23:0] rsp_temp_out,
   output logic [26:0]        rsp_press_out,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [63:0]        csr_pwdata,
   output logic [63:0]        csr_prdata,
   output logic               csr_pready
);

   calib_type          calib;
   logic               adv;
   logic               temp_valid, press_valid;
   logic signed [27:0] t_val;
   logic signed [23:0] tq_a, tq_b;
   logic [23:0]        pr_val;
   logic signed [57:0] sum_val;

   // Hold every stage while the result waits
   assign adv        = !rsp_valid || rsp_ready;
   assign req_ready  = adv;
   assign csr_pready = 1'b1;

   btpc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .calib       (calib)
   );

   btpc_temp #(.FRAC_BITS(FRAC_BITS)) u_temp (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .press_raw (req_press_raw),
      .temp_raw  (req_temp_raw),
      .calib     (calib),
      .out_valid (temp_valid),
      .t_out     (t_val),
      .tq_out    (tq_a),
      .pr_out    (pr_val)
   );

   btpc_press u_press (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (temp_valid),
      .t_in      (t_val),
      .tq_in     (tq_a),
      .pr_in     (pr_val),
      .calib     (calib),
      .out_valid (press_valid),
      .sum_out   (sum_val),
      .tq_out    (tq_b)
   );

   btpc_pdiv #(.FRAC_BITS(FRAC_BITS)) u_pdiv (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (press_valid),
      .sum_in    (sum_val),
      .tq_in     (tq_b),
      .out_valid (rsp_valid),
      .temp_out  (rsp_temp_out),
      .press_out (rsp_press_out)
   );

   `BTPC_ASSERT_IMP(a_stall_from_output, !req_ready, rsp_valid && !rsp_ready, "input held without result backpressure")
   `BTPC_ASSERT_NXT(a_p5_written, csr_psel && csr_penable && csr_pwrite && (csr_paddr[4:3] == REG_PRESS_MID), calib.p5 == $past(csr_pwdata[15:0]), "P5 not taken from write")
   `BTPC_ASSERT_NXT(a_t1_written, csr_psel && csr_penable && csr_pwrite && (csr_paddr[4:3] == REG_TEMP_CALIB), calib.t1 == $past(csr_pwdata[15:0]), "T1 not taken from write")

endmodule

// File: tb/sv/tb_baro_temp_press_compensation_top.sv
// Self-checking testbench for the barometric compensation block.
// Depends on btpc_pkg and baro_temp_press_compensation_top; predicts each result in fixed point.
module tb_baro_temp_press_compensation_top;
   import btpc_pkg::*;

   localparam int FRAC_BITS = 16;
   localparam int PHASES    = 8;
   localparam int RAND_PER_PHASE = 190;
   localparam int DRAIN_CYCLES   = 24;
   localparam int STALL_LIMIT    = 5000;

   typedef logic signed [127:0] wide_t;
   typedef struct {
      logic [23:0] press;
      logic [23:0] temp;
   } sample_t;
   typedef struct {
      logic signed [23:0] temp;
      logic [26:0]        press;
   } reading_t;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [23:0]        req_press_raw = '0;
   logic [23:0]        req_temp_raw = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [23:0] rsp_temp_out;
   logic [26:0]        rsp_press_out;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [4:0]         csr_paddr = '0;
   logic [63:0]        csr_pwdata = '0;
   logic [63:0]        csr_prdata;
   logic               csr_pready;

   // Testbench copy of the calibration registers
   logic [39:0] temp_calib = '0;
   logic [47:0] press_low  = '0;
   logic [31:0] press_mid  = '0;
   logic [47:0] press_high = '0;

   sample_t  pending_samples[$];
   reading_t expected_readings[$];
   int       errors = 0;
   int       samples_in = 0;
   int       readings_out = 0;
   int       idle_cycles = 0;
   int       stall_pct = 0;
   bit       req_taken = 0;
   int       gap_left = 0;
   int       burst_left = 1;
   int       stall_plan[PHASES] = '{0, 30, 0, 50, 10, 70, 20, 0};

   baro_temp_press_compensation_top #(.FRAC_BITS(FRAC_BITS)) DUT (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Compensate one raw pair with the current calibration
   function automatic reading_t compensate(input logic [23:0] pr_raw, input logic [23:0] tr_raw);
      wide_t pr, tr, t1, t2c, t3c, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
      wide_t d, t48, tq, t, ts, tc, c, sum, e, f, r2, pq;
      reading_t r;
      pr = pr_raw;
      tr = tr_raw;
      t1 = temp_calib[15:0];
      t2c = temp_calib[31:16];
      t3c = $signed(temp_calib[39:32]);
      p1 = $signed(press_low[15:0]);
      p2 = $signed(press_low[31:16]);
      p3 = $signed(press_low[39:32]);
      p4 = $signed(press_low[47:40]);
      p5 = press_mid[15:0];
      p6 = press_mid[31:16];
      p7 = $signed(press_high[7:0]);
      p8 = $signed(press_high[15:8]);
      p9 = $signed(press_high[31:16]);
      p10 = $signed(press_high[39:32]);
      p11 = $signed(press_high[47:40]);

      d = tr - t1 * 256;
      t48 = d * t2c * 262144 + d * d * t3c;
      tq = t48 >>> (48 - FRAC_BITS);
      if (tq > 8388607) tq = 8388607;
      if (tq < -8388608) tq = -8388608;

      // Clamp the internal temperature before it feeds pressure
      t = t48 >>> 28;
      if (t > 134217727) t = 134217727;
      if (t < -134217728) t = -134217728;
      ts = (t * t) >>> 20;
      tc = (ts * t) >>> 20;

      sum = p5 * (wide_t'(1) <<< 35) + p6 * t * 64 + p7 * ts * 16 + ((p8 * tc) >>> 3);
      c = (p1 - 16384) * (wide_t'(1) <<< 20) + (((p2 - 16384) * t) >>> 9)
          + ((p3 * ts) >>> 12) + ((p4 * tc) >>> 17);
      sum = sum + ((pr * c) >>> 8);
      r2 = pr * pr;
      e = p9 * (wide_t'(1) <<< 20) + p10 * t;
      sum = sum + ((r2 * e) >>> 36);
      f = pr * p11;
      sum = sum + ((r2 * f) >>> 33);

      if (sum < 0) begin
         pq = 0;
      end else begin
         pq = (sum >>> (32 - FRAC_BITS)) / 100;
         if (pq > 134217727) pq = 134217727;
      end
      r.temp = tq[23:0];
      r.press = pq[26:0];
      return r;
   endfunction

   // Drive the input channel in bursts with random gaps
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_samples.size() > 0) begin
            sample_t s;
            s = pending_samples.pop_front();
            req_valid <= 1'b1;
            req_press_raw <= s.press;
            req_temp_raw <= s.temp;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Stall the result channel at the phase's rate
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // Predict on input transfers, check on result transfers, watch for hangs
   always @(posedge clock) begin
      req_taken = 0;
      if (!reset) begin
         idle_cycles = idle_cycles + 1;
         if (req_valid && req_ready) begin
            req_taken = 1;
            expected_readings.push_back(compensate(req_press_raw, req_temp_raw));
            samples_in = samples_in + 1;
            idle_cycles = 0;
         end
         if (rsp_valid && rsp_ready) begin
            idle_cycles = 0;
            readings_out = readings_out + 1;
            if (expected_readings.size() == 0) begin
               $error("result transfer with nothing expected: temp_out=%0d press_out=%0d",
                      rsp_temp_out, rsp_press_out);
               errors = errors + 1;
            end else begin
               reading_t x;
               x = expected_readings.pop_front();
               if (rsp_temp_out !== x.temp) begin
                  $error("temp_out expected %0d actual %0d", x.temp, rsp_temp_out);
                  errors = errors + 1;
               end
               if (rsp_press_out !== x.press) begin
                  $error("press_out expected %0d actual %0d", x.press, rsp_press_out);
                  errors = errors + 1;
               end
            end
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d cycles without a transfer", idle_cycles);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   task automatic csr_write(input logic [1:0] idx, input logic [63:0] val);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_TEMP_CALIB: temp_calib = val[39:0];
         REG_PRESS_LOW:  press_low = val[47:0];
         REG_PRESS_MID:  press_mid = val[31:0];
         REG_PRESS_HIGH: press_high = val[47:0];
         default: ;
      endcase
   endtask

   // Hold until every transfer is done and the pipeline has drained
   task automatic wait_idle();
      while (pending_samples.size() > 0 || req_valid || expected_readings.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic push_sample(input logic [23:0] pr, input logic [23:0] tr);
      sample_t s;
      s.press = pr;
      s.temp = tr;
      pending_samples.push_back(s);
   endtask

   initial begin
      logic [23:0] tcenter;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph > 0) begin
            wait_idle();
            case (ph)
               1: begin
                  csr_write(REG_TEMP_CALIB, '1);
                  csr_write(REG_PRESS_LOW, '1);
                  csr_write(REG_PRESS_MID, '1);
                  csr_write(REG_PRESS_HIGH, '1);
               end
               2: begin
                  csr_write(REG_TEMP_CALIB, '0);
                  csr_write(REG_PRESS_LOW, '0);
                  csr_write(REG_PRESS_MID, '0);
                  csr_write(REG_PRESS_HIGH, '0);
               end
               3: begin
                  // Plausible factory trim: room temperature near the raw midscale
                  csr_write(REG_TEMP_CALIB, {8'hF9, 16'd19000, 16'd27500});
                  csr_write(REG_PRESS_LOW, {8'h04, 8'hEC, 16'hFFB0, 16'hF800});
                  csr_write(REG_PRESS_MID, {16'd1500, 16'd25000});
                  csr_write(REG_PRESS_HIGH, {8'hFB, 8'h10, 16'h0400, 8'hF6, 8'h08});
               end
               default: begin
                  csr_write(REG_TEMP_CALIB, {$urandom, $urandom});
                  csr_write(REG_PRESS_LOW, {$urandom, $urandom});
                  csr_write(REG_PRESS_MID, {$urandom, $urandom});
                  csr_write(REG_PRESS_HIGH, {$urandom, $urandom});
               end
            endcase
         end
         stall_pct = stall_plan[ph];
         tcenter = {temp_calib[15:0], 8'h00};

         // Field extremes and the zero-offset temperature point
         if (ph < 4) begin
            push_sample(24'h000000, 24'h000000);
            push_sample(24'hFFFFFF, 24'hFFFFFF);
            push_sample(24'h000000, 24'hFFFFFF);
            push_sample(24'hFFFFFF, 24'h000000);
            push_sample(24'h800000, tcenter);
            push_sample(24'h555555, tcenter + 24'd1);
         end

         for (int i = 0; i < RAND_PER_PHASE; i++) begin
            logic [23:0] pr, tr;
            pr = 24'($urandom);
            tr = 24'($urandom);
            case ($urandom_range(0, 5))
               0, 1: tr = tcenter + 24'($signed($urandom_range(0, 2097152)) - 1048576);
               2: tr = tcenter + 24'($signed($urandom_range(0, 131072)) - 65536);
               3: pr = ($urandom_range(0, 1) == 1) ? 24'(24'hFFFFFF - $urandom_range(0, 255))
                                                    : 24'($urandom_range(0, 255));
               default: ;
            endcase
            push_sample(pr, tr);
         end
      end

      wait_idle();
      $display("%0d sample pairs over %0d calibration sets, %0d results checked",
               samples_in, PHASES, readings_out);
      $display("calibration at reset, all ones, all zeros, typical and random; stalls 0-70%%");
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+hdl
hdl/btpc_pkg.sv
hdl/btpc_csr.sv
hdl/btpc_temp.sv
hdl/btpc_press.sv
hdl/btpc_pdiv.sv
hdl/baro_temp_press_compensation_top.sv
tb/sv/tb_baro_temp_press_compensation_top.sv
